// ----- src/packed_pixel_palette_unpacker_unit_macros.svh -----
// ----------------------------------------------------------------------------
// packed pixel palette unpacker assertion macros
// concurrent check wrappers shared by the unpacker modules
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_PALETTE_UNPACKER_UNIT_MACROS_SVH
`define PACKED_PIXEL_PALETTE_UNPACKER_UNIT_MACROS_SVH

// check on clk_i, off while rst_ni is low
`define PPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on clk_i, also during reset
`define PPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg
// types and constants shared by the packed pixel palette unpacker
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

  localparam int unsigned MaxWidth     = 2047;
  localparam int unsigned PalDepth     = 256;
  localparam int unsigned PalIdxW      = $clog2(PalDepth);
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);
  localparam int unsigned QCntW        = $clog2(QDepth + 1);
  localparam int unsigned AddrW        = 22;
  localparam int unsigned OffsW        = 12;
  localparam int unsigned HeaderBytes  = 4;
  localparam int unsigned PalEntrySize = 4;
  localparam int unsigned CfgDataW     = 24;

  typedef enum logic [1:0] {
    OP_PAL_WRITE  = 2'd0,
    OP_LINE_START = 2'd1,
    OP_DATA_BYTE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_FILL_COLOR   = 2'd2,
    CFG_SOURCE_FILE  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    RK_ADDRESS = 1'b0,
    RK_PIXEL   = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [10:0] image_width;
    logic [23:0] fill_color;
    logic        source_is_file;
  } cfg_t;

  // one queued command, fields used according to op
  typedef struct packed {
    op_e              op;
    logic [7:0]       pal_index;
    logic [23:0]      pal_rgb;
    logic [7:0]       pal_opacity;
    logic [AddrW-1:0] addr_prod;
    logic [OffsW-1:0] addr_offs;
    logic [10:0]      line_len;
    logic [2:0]       start_bitpos;
    logic [7:0]       data;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- src/ppu_queue.sv -----
// ----------------------------------------------------------------------------
// ppu_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none
`include "packed_pixel_palette_unpacker_unit_macros.svh"

module ppu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ppu_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output ppu_pkg::q_entry_t head_o,
  output logic              full_o,
  output logic              empty_o
);
  import ppu_pkg::*;

  q_entry_t          slots_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, wptr_d;
  logic [QPtrW-1:0]  rptr_q, rptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? QPtrW'(wptr_q + 1'b1) : wptr_q;
    rptr_d  = pop_i ? QPtrW'(rptr_q + 1'b1) : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = QCntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = QCntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= entry_i;
    end
  end

  `PPU_ASSERT(a_q_no_overflow, push_i |-> (!full_o || pop_i), "queue push while full")
  `PPU_ASSERT(a_q_no_underflow, pop_i |-> !empty_o, "queue pop while empty")
  `PPU_ASSERT(a_q_count_up, (push_i && !pop_i) |=> (count_q == QCntW'($past(count_q) + 1'b1)),
              "queue count did not grow on push")

endmodule

`default_nettype wire

// ----- src/ppu_front.sv -----
// ----------------------------------------------------------------------------
// ppu_front
// input stage: takes items, drops unused codes, prepares line addresses
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppu_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        palette_index_i,
  input  logic [23:0]       palette_rgb_i,
  input  logic [7:0]        palette_opacity_i,
  input  logic [10:0]       start_x_i,
  input  logic [10:0]       row_i,
  input  logic [10:0]       line_length_i,
  input  logic [7:0]        data_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output ppu_pkg::q_entry_t entry_o
);
  import ppu_pkg::*;

  logic             valid_q, valid_d;
  q_entry_t         entry_q, entry_d;
  logic             accept;
  logic             known_op;
  logic [1:0]       lb;
  logic [3:0]       bpp;
  logic [1:0]       shift;
  logic [2:0]       ppb_mask;
  logic [10:0]      stride;
  logic [AddrW-1:0] prod;
  logic [OffsW-1:0] pal_skip;
  logic [OffsW-1:0] hdr;
  logic [3:0]       sub_pos;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !q_full_i;
  assign entry_o    = entry_q;

  // format geometry
  assign lb       = cfg_i.pixel_format[1:0];
  assign bpp      = 4'(4'd1 << lb);
  assign shift    = 2'(2'd3 - lb);
  assign ppb_mask = 3'(4'(4'd8 >> lb) - 4'd1);

  // row stride in bytes, rounded up
  assign stride = 11'(({1'b0, cfg_i.image_width} + {9'd0, ppb_mask}) >> shift);
  assign prod   = stride * row_i;

  assign pal_skip = cfg_i.pixel_format[2] ? OffsW'(OffsW'(PalEntrySize) << bpp) : '0;
  assign hdr      = cfg_i.source_is_file ? OffsW'(HeaderBytes) : '0;
  assign sub_pos  = 4'({1'b0, start_x_i[2:0] & ppb_mask} << lb);

  always_comb begin
    known_op = 1'b1;
    unique case (opcode_i) inside
      OP_PAL_WRITE, OP_LINE_START, OP_DATA_BYTE: known_op = 1'b1;
      default:                                   known_op = 1'b0;
    endcase
  end

  always_comb begin
    entry_d              = entry_q;
    entry_d.op           = op_e'(opcode_i);
    entry_d.pal_index    = palette_index_i;
    entry_d.pal_rgb      = palette_rgb_i;
    entry_d.pal_opacity  = palette_opacity_i;
    entry_d.addr_prod    = prod;
    entry_d.addr_offs    = OffsW'(start_x_i >> shift) + pal_skip + hdr;
    entry_d.line_len     = (line_length_i > 11'(MaxWidth)) ? 11'(MaxWidth) : line_length_i;
    entry_d.start_bitpos = 3'(4'd8 - bpp - sub_pos);
    entry_d.data         = data_byte_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = known_op;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ppu_back.sv -----
// ----------------------------------------------------------------------------
// ppu_back
// executes queued commands: palette store, line setup, pixel unpacking
// ----------------------------------------------------------------------------
`default_nettype none
`include "packed_pixel_palette_unpacker_unit_macros.svh"

module ppu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppu_pkg::cfg_t     cfg_i,
  input  logic              head_valid_i,
  input  ppu_pkg::q_entry_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [21:0]       byte_address_o,
  output logic [23:0]       pixel_color_o,
  output logic [7:0]        pixel_alpha_o,
  output logic              last_of_byte_o,
  output logic              line_done_o
);
  import ppu_pkg::*;

  logic [2:0]        bitpos_q, bitpos_d;
  logic [10:0]       rem_q, rem_d;
  logic [10:0]       rem_next;
  logic [1:0]        lb;
  logic [3:0]        bpp;
  logic [7:0]        pix_mask;
  logic [7:0]        val;
  logic              end_byte;
  logic              in_range;
  logic [7:0]        scaled;
  logic              adv;
  logic              fire;
  logic              pal_we;
  logic              rd_en;

  logic [31:0]       pal_mem [PalDepth];
  logic [31:0]       rd_q;

  logic              out_valid_q;
  result_kind_e      kind_q, kind_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [23:0]       color_q, color_d;
  logic [7:0]        alpha_q, alpha_d;
  logic              use_mem_q, use_mem_d;
  logic              last_q, last_d;
  logic              done_q, done_d;

  assign lb       = cfg_i.pixel_format[1:0];
  assign bpp      = 4'(4'd1 << lb);
  assign pix_mask = 8'(9'(9'd1 << bpp) - 9'd1);
  assign val      = 8'(head_i.data >> bitpos_q) & pix_mask;
  assign end_byte = ({1'b0, bitpos_q} < bpp);
  assign in_range = ({1'b0, val} < 9'(PalDepth));
  assign rem_next = rem_q - 11'd1;
  assign adv      = !out_valid_q || !out_stall_i;

  // alpha scaling to 0..255 is bit replication of the field
  always_comb begin
    case (lb)
      2'd0:    scaled = {8{val[0]}};
      2'd1:    scaled = {4{val[1:0]}};
      2'd2:    scaled = {2{val[3:0]}};
      default: scaled = val;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    fire      = 1'b0;
    pal_we    = 1'b0;
    rd_en     = 1'b0;
    rem_d     = rem_q;
    bitpos_d  = bitpos_q;
    kind_d    = RK_ADDRESS;
    addr_d    = '0;
    color_d   = '0;
    alpha_d   = '0;
    use_mem_d = 1'b0;
    last_d    = 1'b0;
    done_d    = 1'b0;
    if (head_valid_i) begin
      unique case (head_i.op)
        OP_PAL_WRITE: begin
          pal_we = ({1'b0, head_i.pal_index} < 9'(PalDepth));
          pop_o  = 1'b1;
        end
        OP_LINE_START: begin
          if (adv) begin
            fire     = 1'b1;
            pop_o    = 1'b1;
            addr_d   = AddrW'(head_i.addr_prod + AddrW'(head_i.addr_offs));
            rem_d    = head_i.line_len;
            bitpos_d = head_i.start_bitpos;
          end
        end
        OP_DATA_BYTE: begin
          if (rem_q == '0) begin
            // nothing left in the line, byte is dropped
            pop_o = 1'b1;
          end else if (adv) begin
            fire     = 1'b1;
            kind_d   = RK_PIXEL;
            rem_d    = rem_next;
            bitpos_d = end_byte ? 3'(4'd8 - bpp) : 3'({1'b0, bitpos_q} - bpp);
            last_d   = end_byte || (rem_next == '0);
            done_d   = (rem_next == '0);
            pop_o    = end_byte || (rem_next == '0);
            if (cfg_i.pixel_format[2]) begin
              use_mem_d = in_range;
              rd_en     = in_range;
            end else begin
              color_d = cfg_i.fill_color;
              alpha_d = scaled;
            end
          end
        end
        default: pop_o = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[head_i.pal_index[PalIdxW-1:0]] <= {head_i.pal_rgb, head_i.pal_opacity};
    end
    if (rd_en) begin
      rd_q <= pal_mem[val[PalIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitpos_q    <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bitpos_q <= bitpos_d;
      rem_q    <= rem_d;
      if (adv) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q    <= kind_d;
      addr_q    <= addr_d;
      color_q   <= color_d;
      alpha_q   <= alpha_d;
      use_mem_q <= use_mem_d;
      last_q    <= last_d;
      done_q    <= done_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign byte_address_o = addr_q;
  assign pixel_color_o  = use_mem_q ? rd_q[31:8] : color_q;
  assign pixel_alpha_o  = use_mem_q ? rd_q[7:0] : alpha_q;
  assign last_of_byte_o = last_q;
  assign line_done_o    = done_q;

  `PPU_ASSERT(a_done_is_last, (out_valid_q && done_q) |-> last_q,
              "line end without end of byte")
  `PPU_ASSERT_ALWAYS(a_one_producer, fire |-> !pal_we, "pixel and palette write in one cycle")

endmodule

`default_nettype wire

// ----- src/packed_pixel_palette_unpacker_unit.sv -----
// a line start or data byte passes the front register and the queue on its way to the result register
// throughput: one input transfer per cycle while the queue has room; one result per cycle while out_stall_i is low
// a data byte holds the back end until all the pixels it yields (1 to 8) are out, the pixel loop
// palette writes and dropped bytes pass the back end without a result, unused opcodes stop in front
// reset: async active low, clears queue, line state and config (format 0, width 1, others 0)
// palette contents are not cleared by reset and are valid only once written
// ----------------------------------------------------------------------------
// packed_pixel_palette_unpacker_unit
// decodes rows of 1/2/4/8 bit packed pixels in alpha or indexed formats
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_palette_unpacker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  palette_index_i,
  input  logic [23:0] palette_rgb_i,
  input  logic [7:0]  palette_opacity_i,
  input  logic [10:0] start_x_i,
  input  logic [10:0] row_i,
  input  logic [10:0] line_length_i,
  input  logic [7:0]  data_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [21:0] byte_address_o,
  output logic [23:0] pixel_color_o,
  output logic [7:0]  pixel_alpha_o,
  output logic        last_of_byte_o,
  output logic        line_done_o
);
  import ppu_pkg::*;

  cfg_t     cfg_q;
  q_entry_t front_entry;
  q_entry_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format   <= 3'd0;
      cfg_q.image_width    <= 11'd1;
      cfg_q.fill_color     <= 24'd0;
      cfg_q.source_is_file <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PIXEL_FORMAT: cfg_q.pixel_format   <= cfg_data_i[2:0];
        CFG_IMAGE_WIDTH:  cfg_q.image_width    <= cfg_data_i[10:0];
        CFG_FILL_COLOR:   cfg_q.fill_color     <= cfg_data_i;
        CFG_SOURCE_FILE:  cfg_q.source_is_file <= cfg_data_i[0];
        default:          cfg_q                <= cfg_q;
      endcase
    end
  end

  // front end: takes transfers, drops opcode 3, precomputes stride * row and offsets
  ppu_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .palette_index_i   (palette_index_i),
    .palette_rgb_i     (palette_rgb_i),
    .palette_opacity_i (palette_opacity_i),
    .start_x_i         (start_x_i),
    .row_i             (row_i),
    .line_length_i     (line_length_i),
    .data_byte_i       (data_byte_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .entry_o           (front_entry)
  );

  // decoupling queue, lets the front keep taking bytes while pixels drain
  ppu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back end: palette memory, line state, one pixel per cycle into the result register while out_stall_i is low
  ppu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_valid_i   (!q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .byte_address_o (byte_address_o),
    .pixel_color_o  (pixel_color_o),
    .pixel_alpha_o  (pixel_alpha_o),
    .last_of_byte_o (last_of_byte_o),
    .line_done_o    (line_done_o)
  );

endmodule

`default_nettype wire
